[rtl/core/tps_pkg.sv]
// Shared widths, register indexes and saturation helpers for the trapezoidal pulse shaper.
`timescale 1ns / 1ps

package tps_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 13;
    localparam int SAMPLE_TDATA_W = 16;
    localparam int LEN_W      = 10;
    localparam int GAIN_W     = 12;
    localparam int DIFF_W     = 15;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int TRAP_W     = 40;
    localparam int R_W        = TRAP_W + 5;
    localparam int SHAPE_W    = 48;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_RISE_LENGTH   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_LENGTH    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DECAY_GAIN_Q4 = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [LEN_W-1:0]  RISE_LENGTH_RST   = 10'd10;
    localparam logic [LEN_W-1:0]  GAP_LENGTH_RST    = 10'd30;
    localparam logic [GAIN_W-1:0] DECAY_GAIN_Q4_RST = 12'd280;

    // Per-tap control carried from address generation to the difference stage.
    typedef struct packed {
        logic active;   // tap lies inside the current waveform and the delay line
        logic current;  // zero delay: the tap is the incoming sample itself
    } tps_tap_t;

    // Clamp a one-bit-wider sum to the signed trapezoid accumulator range.
    function automatic logic signed [TRAP_W-1:0] sat_trap(input logic signed [TRAP_W:0] v);
        logic signed [TRAP_W-1:0] res;
        if (v[TRAP_W] != v[TRAP_W-1])
        begin
            res = v[TRAP_W] ? {1'b1, {(TRAP_W-1){1'b0}}} : {1'b0, {(TRAP_W-1){1'b1}}};
        end
        else
        begin
            res = v[TRAP_W-1:0];
        end
        return res;
    endfunction

    // Clamp a one-bit-wider sum to the signed shaped output range.
    function automatic logic signed [SHAPE_W-1:0] sat_shape(input logic signed [SHAPE_W:0] v);
        logic signed [SHAPE_W-1:0] res;
        if (v[SHAPE_W] != v[SHAPE_W-1])
        begin
            res = v[SHAPE_W] ? {1'b1, {(SHAPE_W-1){1'b0}}} : {1'b0, {(SHAPE_W-1){1'b1}}};
        end
        else
        begin
            res = v[SHAPE_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/tps_history.sv]
// Sample history: two synchronous memories giving three registered taps per cycle while rd_en is high.
`timescale 1ns / 1ps

module tps_history #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                                   clk,
    input  logic                                   rd_en,
    input  logic                                   wr_en,
    input  logic [AW-1:0]                          wr_addr,
    input  logic signed [tps_pkg::SAMPLE_W-1:0]    wr_data,
    input  logic [AW-1:0]                          rd_addr_k,
    input  logic [AW-1:0]                          rd_addr_l,
    input  logic [AW-1:0]                          rd_addr_kl,
    output logic signed [tps_pkg::SAMPLE_W-1:0]    rd_data_k,
    output logic signed [tps_pkg::SAMPLE_W-1:0]    rd_data_l,
    output logic signed [tps_pkg::SAMPLE_W-1:0]    rd_data_kl
);
    import tps_pkg::*;

    logic signed [SAMPLE_W-1:0] mem_kl_pair [DEPTH];
    logic signed [SAMPLE_W-1:0] mem_sum     [DEPTH];

    // First copy serves the rise and gap taps.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_kl_pair[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_k <= mem_kl_pair[rd_addr_k];
            rd_data_l <= mem_kl_pair[rd_addr_l];
        end
    end

    // Second copy serves the combined rise plus gap tap.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_sum[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_kl <= mem_sum[rd_addr_kl];
        end
    end

endmodule

[rtl/core/trapezoidal_pulse_shaper.sv]
// Top level of the trapezoidal pulse shaper: stream ports, tap control and accumulators.
`timescale 1ns / 1ps
//
// Usage: each request on the s_ side carries one baseline-corrected detector
// sample in s_tdata and a waveform-start flag in s_tuser. For every accepted
// request the block delivers exactly one request on the m_ side holding the
// trapezoid output times 16, saturated to 48 bits. Asserting the start flag
// begins a new waveform: earlier samples read as zero and both running sums
// restart from zero with that sample.
// Throughput is one sample per clock unless the receiver holds m_tready low;
// the pipeline is memory read, difference,
// trapezoid sum with gain multiply, shaping term, output sum and register.
// The rate is set by the accumulator loops, each closed through one register,
// and one read per tap on the history memories each cycle.
// After reset the configuration registers hold rise 10, gap 10 plus 20, gain
// 280, and the stream behaves as if a waveform began at reset; no clearing
// pass is needed. When the receiver holds m_tready low, stages fill up one by
// one and s_tready falls only once every stage holds an item.
// Configuration writes on cfg_we take effect at once and are meant for idle.
//
module trapezoidal_pulse_shaper #(
    parameter int DELAY_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Input stream.
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [tps_pkg::SAMPLE_TDATA_W-1:0]     s_tdata,   // [12:0] sample, zero above
    input  logic                                   s_tuser,   // [0] waveform_start
    // Output stream.
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [tps_pkg::SHAPE_W-1:0]            m_tdata,   // [47:0] shaped_q4
    // Configuration write port.
    input  logic                                   cfg_we,
    input  logic [tps_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [tps_pkg::GAIN_W-1:0]             cfg_wdata
);
    import tps_pkg::*;

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int CNT_W = $clog2(DELAY_DEPTH + 1);
    localparam int CW    = (CNT_W > LEN_W + 1) ? CNT_W : LEN_W + 1;

    // Configuration registers.
    logic [LEN_W-1:0]  rise_reg;
    logic [LEN_W-1:0]  gap_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_reg <= RISE_LENGTH_RST;
            gap_reg  <= GAP_LENGTH_RST;
            gain_reg <= DECAY_GAIN_Q4_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_RISE_LENGTH:   rise_reg <= cfg_wdata[LEN_W-1:0];
                REG_GAP_LENGTH:    gap_reg  <= cfg_wdata[LEN_W-1:0];
                REG_DECAY_GAIN_Q4: gain_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Handshake chain: a stage takes a new item when it is empty or its item moves on.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic accept;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
            if (rdy5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    // Tap address: slot that lies the given delay behind the current slot.
    function automatic logic [AW-1:0] tap_addr(input logic [AW-1:0] cur,
                                               input logic [CW-1:0] dly);
        logic [CW:0] sum;
        sum = (CW+1)'(cur) + (CW+1)'(DELAY_DEPTH) - (CW+1)'(dly);
        if (sum >= (CW+1)'(DELAY_DEPTH))
        begin
            sum = sum - (CW+1)'(DELAY_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Tap control: zero outside the waveform or the delay line, the sample itself at zero delay.
    function automatic tps_tap_t tap_ctrl(input logic [CW-1:0] dly,
                                          input logic [CNT_W-1:0] seen);
        tps_tap_t t;
        t.current = (dly == '0);
        t.active  = (dly != '0) && (dly < CW'(DELAY_DEPTH)) && (dly <= CW'(seen));
        return t;
    endfunction

    // Tap value as seen by the difference stage.
    function automatic logic signed [SAMPLE_W-1:0] tap_val(input tps_tap_t t,
                                                           input logic signed [SAMPLE_W-1:0] x,
                                                           input logic signed [SAMPLE_W-1:0] q);
        logic signed [SAMPLE_W-1:0] v;
        if (t.current)
        begin
            v = x;
        end
        else if (t.active)
        begin
            v = q;
        end
        else
        begin
            v = '0;
        end
        return v;
    endfunction

    // Write pointer and fill count, both restarted by a waveform start.
    logic [AW-1:0]    wp_reg, wp_next, cur0;
    logic [CNT_W-1:0] seen_reg, seen_next, seen0;
    logic [CW-1:0]    dly_k, dly_l, dly_kl;
    logic signed [SAMPLE_W-1:0] sample0;

    assign sample0 = s_tdata[SAMPLE_W-1:0];
    assign cur0    = s_tuser ? '0 : wp_reg;
    assign seen0   = s_tuser ? '0 : seen_reg;
    assign dly_k   = CW'(rise_reg);
    assign dly_l   = CW'(gap_reg);
    assign dly_kl  = CW'(rise_reg) + CW'(gap_reg);

    assign wp_next   = (cur0 == AW'(DELAY_DEPTH - 1)) ? '0 : cur0 + 1'b1;
    assign seen_next = (seen0 < CNT_W'(DELAY_DEPTH)) ? seen0 + 1'b1 : seen0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            seen_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= wp_next;
            seen_reg <= seen_next;
        end
    end

    // History memories: write the sample and read its three taps.
    logic signed [SAMPLE_W-1:0] q_k, q_l, q_kl;

    tps_history #(
        .DEPTH (DELAY_DEPTH)
    ) u_history (
        .clk        (clk),
        .rd_en      (rdy1),
        .wr_en      (accept),
        .wr_addr    (cur0),
        .wr_data    (sample0),
        .rd_addr_k  (tap_addr(cur0, dly_k)),
        .rd_addr_l  (tap_addr(cur0, dly_l)),
        .rd_addr_kl (tap_addr(cur0, dly_kl)),
        .rd_data_k  (q_k),
        .rd_data_l  (q_l),
        .rd_data_kl (q_kl)
    );

    // Stage 1: sample, start flag and tap control alongside the memory read.
    logic signed [SAMPLE_W-1:0] x1_reg;
    logic                       start1_reg;
    tps_tap_t                   tk1_reg, tl1_reg, tkl1_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            x1_reg     <= sample0;
            start1_reg <= s_tuser;
            tk1_reg    <= tap_ctrl(dly_k, seen0);
            tl1_reg    <= tap_ctrl(dly_l, seen0);
            tkl1_reg   <= tap_ctrl(dly_kl, seen0);
        end
    end

    // Stage 2: double difference of the sample and its delayed copies.
    logic signed [DIFF_W-1:0] diff_next, diff2_reg;
    logic                     start2_reg;

    assign diff_next = DIFF_W'(x1_reg)
                     - DIFF_W'(tap_val(tk1_reg, x1_reg, q_k))
                     - DIFF_W'(tap_val(tl1_reg, x1_reg, q_l))
                     + DIFF_W'(tap_val(tkl1_reg, x1_reg, q_kl));

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            diff2_reg  <= diff_next;
            start2_reg <= start1_reg;
        end
    end

    // Stage 3: trapezoid accumulator and pole-zero gain product.
    logic signed [TRAP_W-1:0] trap_reg, trap_next, trap_base;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     start3_reg;

    assign trap_base = start2_reg ? '0 : trap_reg;
    assign trap_next = sat_trap((TRAP_W+1)'(trap_base) + (TRAP_W+1)'(diff2_reg));
    assign prod_next = PROD_W'($signed({1'b0, gain_reg})) * PROD_W'(diff2_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trap_reg <= '0;
        end
        else if (rdy3 && v2_reg)
        begin
            trap_reg <= trap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            prod_reg   <= prod_next;
            start3_reg <= start2_reg;
        end
    end

    // Stage 4: shaping term, sixteen times the trapezoid sum plus the gain product.
    logic signed [R_W-1:0] r_reg, r_next;
    logic                  start4_reg;

    assign r_next = (R_W'(trap_reg) <<< 4) + R_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            r_reg      <= r_next;
            start4_reg <= start3_reg;
        end
    end

    // Stage 5: shaped output accumulator, which is also the output register.
    logic signed [SHAPE_W-1:0] shape_reg, shape_next, shape_base;

    assign shape_base = start4_reg ? '0 : shape_reg;
    assign shape_next = sat_shape((SHAPE_W+1)'(shape_base) + (SHAPE_W+1)'(r_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg <= '0;
        end
        else if (rdy5 && v4_reg)
        begin
            shape_reg <= shape_next;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = shape_reg;

endmodule

[tb/sv/tb_trapezoidal_pulse_shaper.sv]
// Self-checking testbench for the trapezoidal pulse shaper with a scoreboard and stream drivers.
`timescale 1ns / 1ps

module tb_trapezoidal_pulse_shaper;

    import tps_pkg::*;

    localparam int DEPTH         = 1024;
    localparam int DEPTH_AW      = $clog2(DEPTH);
    localparam int PHASE_ITEMS   = 130;
    localparam int HOLD_LEN      = 64;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 2000;

    localparam longint TRAP_LIMIT  = 64'sh0000_007F_FFFF_FFFF;
    localparam longint SHAPE_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;

    // Predicts the shaped output of every accepted sample and checks the results in order.
    class shaper_scoreboard;
        logic signed [SAMPLE_W-1:0] history [DEPTH];
        int unsigned                wr_slot;
        int unsigned                seen;
        longint                     trap_sum;
        longint                     shape_sum;
        int unsigned                rise_len;
        int unsigned                gap_len;
        int unsigned                gain_q4;
        logic [SHAPE_W-1:0]         shaped_q [$];
        int                         errors;
        int                         samples;
        int                         starts;
        int                         checked;
        int                         saturated;

        function new();
            clear_waveform();
            rise_len  = 32'(RISE_LENGTH_RST);
            gap_len   = 32'(GAP_LENGTH_RST);
            gain_q4   = 32'(DECAY_GAIN_Q4_RST);
            errors    = 0;
            samples   = 0;
            starts    = 0;
            checked   = 0;
            saturated = 0;
        endfunction

        function void clear_waveform();
            foreach (history[i])
            begin
                history[i] = '0;
            end
            wr_slot   = 0;
            seen      = 0;
            trap_sum  = 0;
            shape_sum = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [GAIN_W-1:0] value);
            case (addr)
                REG_RISE_LENGTH:   rise_len = 32'(value[LEN_W-1:0]);
                REG_GAP_LENGTH:    gap_len  = 32'(value[LEN_W-1:0]);
                REG_DECAY_GAIN_Q4: gain_q4  = 32'(value);
                default: ;
            endcase
        endfunction

        // A tap reads zero when it reaches before the waveform start or past the delay line.
        function longint tap_value(int unsigned cur, int unsigned delay);
            if (delay >= DEPTH || delay > seen)
            begin
                return 0;
            end
            return longint'(history[DEPTH_AW'((cur + DEPTH - delay) % DEPTH)]);
        endfunction

        function longint clip(longint v, longint limit);
            if (v > limit)
            begin
                return limit;
            end
            if (v < -limit - 1)
            begin
                return -limit - 1;
            end
            return v;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic start);
            longint      x;
            longint      diff;
            longint      shaping;
            int unsigned cur;
            x = longint'(smp);
            if (start)
            begin
                clear_waveform();
                starts++;
            end
            cur = wr_slot % DEPTH;
            history[DEPTH_AW'(cur)] = smp;
            diff = x - tap_value(cur, rise_len) - tap_value(cur, gap_len)
                   + tap_value(cur, rise_len + gap_len);
            trap_sum  = clip(trap_sum + diff, TRAP_LIMIT);
            shaping   = trap_sum * 16 + longint'(gain_q4) * diff;
            shape_sum = clip(shape_sum + shaping, SHAPE_LIMIT);
            if (shape_sum == SHAPE_LIMIT || shape_sum == -SHAPE_LIMIT - 1)
            begin
                saturated++;
            end
            wr_slot = (cur + 1) % DEPTH;
            if (seen < DEPTH)
            begin
                seen++;
            end
            samples++;
            shaped_q.insert(shaped_q.size(), shape_sum[SHAPE_W-1:0]);
        endfunction

        task check_result(logic [SHAPE_W-1:0] got);
            logic [SHAPE_W-1:0] want;
            if (shaped_q.size() == 0)
            begin
                report($sformatf("shaped_q4 %0d arrived with no sample outstanding",
                                 $signed(got)));
                return;
            end
            want = shaped_q.pop_front();
            checked++;
            if (got !== want)
            begin
                report($sformatf("shaped_q4 of result %0d is %0d, predicted %0d",
                                 checked, $signed(got), $signed(want)));
            end
        endtask

        function int outstanding();
            return shaped_q.size();
        endfunction

        // Prints one line per mismatch, capped so a broken block cannot flood the log.
        task report(string msg);
            if (errors < 100)
            begin
                $display("MISMATCH at %0t: %s", $time, msg);
            end
            errors++;
        endtask
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [SAMPLE_TDATA_W-1:0]  s_tdata   = '0;  // [12:0] sample, zero above
    logic                       s_tuser   = 1'b0; // [0] waveform_start
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [SHAPE_W-1:0]         m_tdata;         // [47:0] shaped_q4
    logic                       cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]      cfg_addr  = '0;
    logic [GAIN_W-1:0]          cfg_wdata = '0;

    shaper_scoreboard sb = new();
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    bit hold_request  = 1'b0;
    int hold_count    = 0;
    int quiet_cycles  = 0;
    int input_stalls  = 0;

    trapezoidal_pulse_shaper #(
        .DELAY_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Monitor both streams on the pre-edge values and track how long nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (s_tvalid && s_tready)
            begin
                sb.note_sample(s_tdata[SAMPLE_W-1:0], s_tuser);
            end
            if (s_tvalid && !s_tready)
            begin
                input_stalls++;
            end
            if (m_tvalid && m_tready)
            begin
                sb.check_result(m_tdata);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here when requested.
    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                hold_count++;
                if (hold_count >= HOLD_LEN)
                begin
                    hold_request = 1'b0;
                    hold_count   = 0;
                end
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Ends the run when neither stream has moved for too long.
    initial
    begin : watchdog
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("Timeout: no request accepted for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Offers one sample after a random idle gap and holds it until accepted.
    task automatic send_item(input int smp, input logic start);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(SAMPLE_TDATA_W-SAMPLE_W){1'b0}}, SAMPLE_W'(smp)};
        s_tuser  <= start;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering samples and waits until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [GAIN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        sb.set_reg(addr, value);
        @(posedge clk);
    endtask

    // Registers change only once the block has gone idle.
    task automatic configure(input int rise, input int gap, input int gain);
        drain();
        write_reg(REG_RISE_LENGTH, GAIN_W'(rise));
        write_reg(REG_GAP_LENGTH, GAIN_W'(gap));
        write_reg(REG_DECAY_GAIN_Q4, GAIN_W'(gain));
        cfg_we <= 1'b0;
    endtask

    // Random waveforms: mostly a start flag, a quiet baseline, then a decaying pulse.
    task automatic run_phase(input int src_pct, input int sink_pct, input int rise,
                             input int gap, input int gain, input int count, input bit hold);
        int produced;
        int span;
        int wave_len;
        int rise_at;
        int amp;
        int pos;
        int value;
        configure(rise, gap, gain);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        hold_request   = hold;
        span = (rise % DEPTH) + (gap % DEPTH) + 32;
        if (span > 400)
        begin
            span = 400;
        end
        produced = 0;
        while (produced < count)
        begin
            wave_len = $urandom_range(span, 1);
            rise_at  = $urandom_range(wave_len - 1, 0);
            amp      = $urandom_range(8191, 0) - 4096;
            for (pos = 0; pos < wave_len && produced < count; pos++)
            begin
                case ($urandom_range(7))
                    0: value = $urandom_range(8191, 0) - 4096;
                    1: value = $urandom_range(1) ? 4095 : -4096;
                    default:
                    begin
                        value = $urandom_range(63, 0) - 32;
                        if (pos >= rise_at)
                        begin
                            value = value + amp;
                            amp   = amp - amp / 16;
                        end
                    end
                endcase
                if (value > 4095)
                begin
                    value = 4095;
                end
                if (value < -4096)
                begin
                    value = -4096;
                end
                send_item(value, (pos == 0) && ($urandom_range(9) != 0));
                produced++;
            end
        end
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration, no start flag yet: field extremes and signs.
        send_item(4095, 1'b0);
        send_item(-4096, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(1, 1'b0);

        // Short delays and full gain: a complete trapezoid, then back-to-back starts.
        configure(2, 3, 4095);
        send_item(4095, 1'b1);
        repeat (8)
        begin
            send_item(4095, 1'b0);
        end
        send_item(-4096, 1'b1);
        repeat (4)
        begin
            send_item(-4096, 1'b0);
        end
        send_item(1, 1'b1);
        send_item(-1, 1'b1);

        // Random phases across idle patterns and register settings.
        run_phase(0, 0, 1, 1, 0, PHASE_ITEMS, 1'b0);
        run_phase(82, 0, 0, 7, 4095, PHASE_ITEMS, 1'b0);
        run_phase(0, 82, 5, 0, 1, PHASE_ITEMS, 1'b0);
        run_phase(16, 16, ($urandom_range(3) << LEN_W) | $urandom_range(64, 1),
                  ($urandom_range(3) << LEN_W) | $urandom_range(64, 1),
                  $urandom_range(4095, 0), PHASE_ITEMS, 1'b0);
        run_phase(0, 0, 1023, 1023, 4095, PHASE_ITEMS, 1'b1);
        run_phase(82, 0, $urandom_range(200, 1), $urandom_range(200, 1),
                  $urandom_range(4095, 0), PHASE_ITEMS, 1'b0);
        run_phase(0, 82, 600, 400, $urandom_range(4095, 0), PHASE_ITEMS, 1'b0);
        run_phase(16, 16, 0, 0, $urandom_range(4095, 0), PHASE_ITEMS, 1'b0);

        // Let the pipeline empty and watch for stray results.
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            sb.report($sformatf("%0d predicted results never arrived", sb.outstanding()));
        end

        $display("Run covered %0d samples in %0d flagged waveforms, %0d results checked.",
                 sb.samples, sb.starts, sb.checked);
        $display("Saturated outputs: %0d; cycles with the input held off: %0d.",
                 sb.saturated, input_stalls);
        if (sb.errors == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
